// ===== rtl/core/tkd_pkg.sv =====
// Shared types and constants of the terminal key decoder.
package tkd_pkg;

    localparam int COORD_BITS  = 12;
    localparam int KEY_BITS    = 9;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [KEY_BITS-1:0]   key_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_ONE   = 2'd2,
        PH_DIGIT = 2'd3
    } phase_t;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_UPPER_O  = 8'h4F;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_CTRL     = 8'h1F;
    localparam logic [7:0] CH_LOWER_Q  = 8'h71;

    localparam key_t KEY_ESC   = 9'd27;
    localparam key_t KEY_LEFT  = 9'd256;
    localparam key_t KEY_RIGHT = 9'd257;
    localparam key_t KEY_UP    = 9'd258;
    localparam key_t KEY_DOWN  = 9'd259;
    localparam key_t KEY_DEL   = 9'd260;
    localparam key_t KEY_HOME  = 9'd261;
    localparam key_t KEY_END   = 9'd262;
    localparam key_t KEY_PGUP  = 9'd263;
    localparam key_t KEY_PGDN  = 9'd264;
    localparam key_t KEY_QUIT  = {1'b0, CH_LOWER_Q & CH_CTRL};

    localparam int ADDR_BITS = 3;
    localparam logic [0:0] REG_COLS = 1'b0;
    localparam logic [0:0] REG_ROWS = 1'b1;

    localparam coord_t COLS_RESET = 12'd80;
    localparam coord_t ROWS_RESET = 12'd24;

    typedef struct packed {
        logic valid;
        key_t key;
    } key_beat_t;

endpackage

// ===== rtl/core/tkd_front.sv =====
// Front end: accepts input beats and decodes escape sequences into key codes.
module tkd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               queue_full,
    output tkd_pkg::key_beat_t push
);

    tkd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      held_reg, held_next;
    logic            accept;
    logic            emit;
    tkd_pkg::key_t   key;
    logic            is_digit;

    function automatic tkd_pkg::key_t bracket_letter(input logic [7:0] b);
        tkd_pkg::key_t k;
        case (b)
            8'h41:   k = tkd_pkg::KEY_UP;
            8'h42:   k = tkd_pkg::KEY_DOWN;
            8'h43:   k = tkd_pkg::KEY_RIGHT;
            8'h44:   k = tkd_pkg::KEY_LEFT;
            8'h48:   k = tkd_pkg::KEY_HOME;
            8'h46:   k = tkd_pkg::KEY_END;
            default: k = tkd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic tkd_pkg::key_t tilde_digit(input logic [7:0] d);
        tkd_pkg::key_t k;
        case (d)
            8'h31:   k = tkd_pkg::KEY_HOME;
            8'h33:   k = tkd_pkg::KEY_DEL;
            8'h34:   k = tkd_pkg::KEY_END;
            8'h35:   k = tkd_pkg::KEY_PGUP;
            8'h36:   k = tkd_pkg::KEY_PGDN;
            8'h37:   k = tkd_pkg::KEY_HOME;
            8'h38:   k = tkd_pkg::KEY_END;
            default: k = tkd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (s_tuser) begin
            phase_next = tkd_pkg::PH_IDLE;
        end else begin
            case (phase_reg)
                tkd_pkg::PH_IDLE: begin
                    if (s_tdata == tkd_pkg::CH_ESC) begin
                        phase_next = tkd_pkg::PH_ESC;
                    end
                end
                tkd_pkg::PH_ESC: begin
                    held_next  = s_tdata;
                    phase_next = tkd_pkg::PH_ONE;
                end
                tkd_pkg::PH_ONE: begin
                    phase_next = tkd_pkg::PH_IDLE;
                    if (held_reg == tkd_pkg::CH_LBRACKET && is_digit) begin
                        held_next  = s_tdata;
                        phase_next = tkd_pkg::PH_DIGIT;
                    end
                end
                default: begin
                    phase_next = tkd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        emit = 1'b0;
        key  = tkd_pkg::KEY_ESC;
        if (s_tuser) begin
            emit = (phase_reg != tkd_pkg::PH_IDLE);
        end else begin
            case (phase_reg)
                tkd_pkg::PH_IDLE: begin
                    emit = (s_tdata != tkd_pkg::CH_ESC);
                    key  = {1'b0, s_tdata};
                end
                tkd_pkg::PH_ESC: begin
                    emit = 1'b0;
                end
                tkd_pkg::PH_ONE: begin
                    emit = 1'b1;
                    if (held_reg == tkd_pkg::CH_LBRACKET) begin
                        emit = !is_digit;
                        key  = bracket_letter(s_tdata);
                    end else if (held_reg == tkd_pkg::CH_UPPER_O) begin
                        if (s_tdata == 8'h48) begin
                            key = tkd_pkg::KEY_HOME;
                        end else if (s_tdata == 8'h46) begin
                            key = tkd_pkg::KEY_END;
                        end
                    end
                end
                default: begin
                    emit = 1'b1;
                    if (s_tdata == tkd_pkg::CH_TILDE) begin
                        key = tilde_digit(held_reg);
                    end
                end
            endcase
        end
    end

    assign push.valid = accept && emit;
    assign push.key   = key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tkd_pkg::PH_IDLE;
            held_reg  <= 8'h00;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== rtl/core/tkd_queue.sv =====
// Short key queue between the decoder front end and the cursor back end.
module tkd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  tkd_pkg::key_beat_t push,
    output logic               full,
    input  logic               pop,
    output logic               out_valid,
    output tkd_pkg::key_t      out_key
);

    localparam int PTR_BITS = $clog2(tkd_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(tkd_pkg::QUEUE_DEPTH + 1);

    tkd_pkg::key_t       mem_reg [tkd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_pop;

    assign full      = (count_reg == CNT_BITS'(tkd_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_key   = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        count_next = count_reg;
        if (push.valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push.valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(tkd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(tkd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/tkd_back.sv =====
// Back end: applies keys to the clamped cursor and holds the result beat.
module tkd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  tkd_pkg::coord_t screen_cols,
    input  tkd_pkg::coord_t screen_rows,
    input  logic            in_valid,
    input  tkd_pkg::key_t   in_key,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output tkd_pkg::key_t   out_key,
    output tkd_pkg::coord_t out_col,
    output tkd_pkg::coord_t out_row,
    output logic            out_quit
);

    tkd_pkg::coord_t col_reg, col_next;
    tkd_pkg::coord_t row_reg, row_next;
    tkd_pkg::coord_t last_col, last_row;
    logic            valid_reg;
    tkd_pkg::key_t   key_reg;
    logic            quit_reg;

    assign last_col = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
    assign last_row = (screen_rows == '0) ? '0 : screen_rows - 1'b1;
    assign pop      = in_valid && (!valid_reg || m_tready);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        case (in_key)
            tkd_pkg::KEY_LEFT: begin
                if (col_reg != '0) col_next = col_reg - 1'b1;
            end
            tkd_pkg::KEY_RIGHT: begin
                if (col_reg < last_col) col_next = col_reg + 1'b1;
            end
            tkd_pkg::KEY_UP: begin
                if (row_reg != '0) row_next = row_reg - 1'b1;
            end
            tkd_pkg::KEY_DOWN: begin
                if (row_reg < last_row) row_next = row_reg + 1'b1;
            end
            tkd_pkg::KEY_HOME: begin
                col_next = '0;
            end
            tkd_pkg::KEY_END: begin
                col_next = last_col;
            end
            tkd_pkg::KEY_PGUP: begin
                row_next = '0;
            end
            tkd_pkg::KEY_PGDN: begin
                if (row_reg < last_row) row_next = last_row;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            key_reg  <= in_key;
            quit_reg <= (in_key == tkd_pkg::KEY_QUIT);
        end
    end

    assign m_tvalid = valid_reg;
    assign out_key  = key_reg;
    assign out_col  = col_reg;
    assign out_row  = row_reg;
    assign out_quit = quit_reg;

endmodule

// ===== rtl/core/terminal_key_decoder_cursor.sv =====
// Top level of the terminal key decoder with clamped cursor.
//
// Input stream (s_): one beat per received byte or read timeout. s_tuser is
// the kind (1 = timeout), s_tdata the byte. Escape sequences ESC [ letter,
// ESC [ digit ~ and ESC O letter become special key codes; a beat that ends
// a key gives one result beat, other beats give none.
// Result stream (m_): key code, cursor column and row after the key, and the
// quit flag for Ctrl-Q. The cursor is clamped to the screen size held in the
// APB registers screen_cols (0x0) and screen_rows (0x4).
// Throughput: one input beat per cycle while s_tready is high. A key passes
// first through the two-entry key queue behind the decoder, then through the
// cursor stage output register, before its result beat appears on m_tvalid.
// When the receiver stalls, the output register holds its beat, the queue
// fills and s_tready drops once both queue entries are taken.
// Reset clears the decoder to idle, the cursor to (0,0), empties the queue
// and loads 80 columns by 24 rows.
module terminal_key_decoder_cursor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // rx_byte[7:0]
    input  logic                           s_tuser,   // kind[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // key_code, cursor_col, cursor_row, pad
    output logic                           m_tuser,   // quit[0]
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tkd_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    tkd_pkg::coord_t    cols_reg, rows_reg;
    tkd_pkg::key_beat_t push;
    logic               queue_full;
    logic               queue_valid;
    tkd_pkg::key_t      queue_key;
    logic               pop;
    tkd_pkg::key_t      out_key;
    tkd_pkg::coord_t    out_col, out_row;
    logic               out_quit;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= tkd_pkg::COLS_RESET;
            rows_reg <= tkd_pkg::ROWS_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == tkd_pkg::REG_COLS) begin
                cols_reg <= pwdata[tkd_pkg::COORD_BITS-1:0];
            end else begin
                rows_reg <= pwdata[tkd_pkg::COORD_BITS-1:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            tkd_pkg::REG_COLS: prdata = {{(32 - tkd_pkg::COORD_BITS){1'b0}}, cols_reg};
            tkd_pkg::REG_ROWS: prdata = {{(32 - tkd_pkg::COORD_BITS){1'b0}}, rows_reg};
            default:           prdata = '0;
        endcase
    end

    tkd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push)
    );

    tkd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (queue_full),
        .pop       (pop),
        .out_valid (queue_valid),
        .out_key   (queue_key)
    );

    tkd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .screen_cols (cols_reg),
        .screen_rows (rows_reg),
        .in_valid    (queue_valid),
        .in_key      (queue_key),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_key     (out_key),
        .out_col     (out_col),
        .out_row     (out_row),
        .out_quit    (out_quit)
    );

    assign m_tdata = {7'b0, out_row, out_col, out_key};
    assign m_tuser = out_quit;

endmodule
